// ===== hdl/scc_pkg.sv =====
package scc_pkg;

  localparam int VW = 5;
  localparam int NODES = 32;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_RUN   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROOT,
    ST_SCAN,
    ST_FINISH,
    ST_POP,
    ST_RETURN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_graph;
    logic add_edge;
    logic clr_visit;
    logic enter_root;
    logic scan_step;
    logic pop_step;
    logic ret_step;
    logic root_step;
  } cmd_t;

  typedef struct packed {
    logic root_visited;
    logic root_last;
    logic scan_end;
    logic is_root;
    logic pop_match;
    logic csp_empty;
  } sts_t;

endpackage

// ===== hdl/scc_ctrl.sv =====
module scc_ctrl
  import scc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_fire,
  input  req_t   in_req,
  input  logic   out_busy,
  input  sts_t   sts,
  output logic   in_ready,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_req == REQ_RUN) state_nxt = ST_CLEAR;
      end
      ST_CLEAR: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sts.root_visited) begin
          if (sts.root_last) state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) state_nxt = ST_FINISH;
      end
      ST_FINISH: state_nxt = sts.is_root ? ST_POP : ST_RETURN;
      ST_POP: begin
        if (!out_busy && sts.pop_match) state_nxt = ST_RETURN;
      end
      ST_RETURN: state_nxt = sts.csp_empty ? ST_ROOT : ST_SCAN;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.add_edge = in_fire && in_req == REQ_ADD;
        cmd.clr_graph = in_fire && in_req == REQ_CLEAR;
        cmd.clr_visit = in_fire && in_req == REQ_RUN;
      end
      ST_ROOT: begin
        cmd.enter_root = !sts.root_visited;
        cmd.root_step = sts.root_visited && !sts.root_last;
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_POP: cmd.pop_step = !out_busy;
      ST_RETURN: cmd.ret_step = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hdl/scc_dp.sv =====
module scc_dp
  import scc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [VW-1:0] in_from,
  input  logic [VW-1:0] in_to,
  input  cmd_t          cmd,
  output sts_t          sts,
  output logic          emit,
  output logic [VW-1:0] emit_vertex,
  output logic          emit_end,
  output logic          emit_last,
  output logic          emit_cycle
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int DW = $clog2(NODES + 2);

  logic [NODES-1:0] adj_r [NODES];
  logic [DW-1:0]    disc_r [NODES];
  logic [DW-1:0]    low_r [NODES];
  logic [NODES-1:0] onst_r;
  logic [IW-1:0]    vstk_r [NODES];
  logic [IW-1:0]    cv_r [NODES];
  logic [CW-1:0]    cn_r [NODES];
  logic [CW-1:0]    vsp_r, csp_r;
  logic [DW-1:0]    cnt_r;
  logic [IW-1:0]    root_r;
  logic             cyc_r;

  logic [IW-1:0] v, w, top, par;
  logic [CW-1:0] nx;
  logic          bit_set, wvalid;
  logic [DW-1:0] cnt_inc;

  assign cnt_inc = cnt_r + DW'(1);
  assign v = cv_r[IW'(csp_r - CW'(1))];
  assign nx = cn_r[IW'(csp_r - CW'(1))];
  assign wvalid = nx < CW'(NODES);
  assign w = IW'(nx);
  assign bit_set = wvalid && adj_r[v][w];
  assign top = vstk_r[IW'(vsp_r - CW'(1))];
  assign par = cv_r[IW'(csp_r - CW'(2))];

  always_comb begin
    sts = '0;
    sts.root_visited = disc_r[root_r] != '0;
    sts.root_last = root_r == IW'(NODES - 1);
    sts.scan_end = !wvalid;
    sts.is_root = low_r[v] == disc_r[v];
    sts.pop_match = top == v;
    sts.csp_empty = csp_r == CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        adj_r[i] <= '0;
        disc_r[i] <= '0;
        low_r[i] <= '0;
      end
      onst_r <= '0;
      vsp_r <= '0;
      csp_r <= '0;
      cnt_r <= '0;
      root_r <= '0;
      cyc_r <= 1'b0;
    end else begin
      emit <= cmd.pop_step;
      if (cmd.clr_graph) begin
        for (int i = 0; i < NODES; i++) adj_r[i] <= '0;
      end
      if (cmd.add_edge && 32'(in_from) < NODES && 32'(in_to) < NODES) begin
        adj_r[IW'(in_from)][IW'(in_to)] <= 1'b1;
      end
      if (cmd.clr_visit) begin
        for (int i = 0; i < NODES; i++) begin
          disc_r[i] <= '0;
          low_r[i] <= '0;
        end
        onst_r <= '0;
        vsp_r <= '0;
        csp_r <= '0;
        cnt_r <= '0;
        root_r <= '0;
        cyc_r <= 1'b0;
      end
      if (cmd.root_step) root_r <= root_r + IW'(1);
      if (cmd.enter_root || (cmd.scan_step && bit_set && disc_r[w] == '0)) begin
        automatic logic [IW-1:0] nv = cmd.enter_root ? root_r : w;
        cnt_r <= cnt_inc;
        disc_r[nv] <= cnt_inc;
        low_r[nv] <= cnt_inc;
        onst_r[nv] <= 1'b1;
        vstk_r[IW'(vsp_r)] <= nv;
        vsp_r <= vsp_r + CW'(1);
        cv_r[IW'(csp_r)] <= nv;
        cn_r[IW'(csp_r)] <= '0;
        csp_r <= csp_r + CW'(1);
        if (cmd.scan_step) cn_r[IW'(csp_r - CW'(1))] <= nx + CW'(1);
      end else if (cmd.scan_step && wvalid) begin
        cn_r[IW'(csp_r - CW'(1))] <= nx + CW'(1);
        if (bit_set && onst_r[w] && disc_r[w] < low_r[v]) low_r[v] <= disc_r[w];
      end
      if (cmd.pop_step) begin
        vsp_r <= vsp_r - CW'(1);
        onst_r[top] <= 1'b0;
        emit_vertex <= VW'(top);
        emit_end <= top == v;
        if (top != v) cyc_r <= 1'b1;
        emit_last <= top == v && vsp_r == CW'(1) && 32'(cnt_r) == NODES;
        emit_cycle <= cyc_r || top != v;
      end
      if (cmd.ret_step) begin
        csp_r <= csp_r - CW'(1);
        if (csp_r != CW'(1) && low_r[v] < low_r[par]) low_r[par] <= low_r[v];
      end
    end
  end

`ifndef ASSERT_OFF
  a_vsp_bound: assert property (@(posedge clk) disable iff (!rst_n) vsp_r <= CW'(NODES))
    else $error("vertex stack overflow");
  a_csp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    csp_r <= vsp_r + CW'(1))
    else $error("call stack deeper than vertex stack");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_step |-> vsp_r != '0)
    else $error("pop from empty stack");
`endif

endmodule

// ===== hdl/strongly_connected_components.sv =====
// Channel | Direction | Payload
// in_     | slave     | tuser: req_type[1:0]; tdata: from_node[4:0], to_node[9:5]
// out_    | master    | tdata: vertex[4:0], component_end[5], has_cycle[6]; tlast
// An edge or clear request is taken while idle and the next may follow at once.
// A run scans the adjacency row of each vertex it enters, plus entry, pop and return steps per vertex.
// The scan walks one adjacency bit per cycle; that loop sets the run length.
// A pop waits until the output register is free and no output from the previous pop is pending.
// Reset clears the graph at once; no clearing pass is needed.
// A stalled output holds the pop sequencer; no request is taken during a run.
module strongly_connected_components
  import scc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // from_node, to_node
  input  logic [1:0]  in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // vertex, component_end, has_cycle
  output logic        out_tlast
);

  cmd_t cmd;
  sts_t sts;
  logic in_fire, emit, e_end, e_last, e_cyc;
  logic [VW-1:0] e_v;
  logic busy;

  assign in_fire = in_tvalid && in_tready;
  assign busy = (out_tvalid && !out_tready) || emit;

  scc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .in_req(req_t'(in_tuser)), .out_busy(busy), .sts(sts),
    .in_ready(in_tready), .cmd(cmd)
  );

  scc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_from(in_tdata[4:0]), .in_to(in_tdata[9:5]),
    .cmd(cmd), .sts(sts), .emit(emit), .emit_vertex(e_v), .emit_end(e_end),
    .emit_last(e_last), .emit_cycle(e_cyc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (emit) begin
      out_tvalid <= 1'b1;
      out_tdata <= {1'b0, e_last & e_cyc, e_end, e_v};
      out_tlast <= e_last;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

endmodule
